@@ hdl/process_table_scheduler_unit_defines.svh @@
// assertion macros shared by the process table scheduler rtl
`ifndef PROCESS_TABLE_SCHEDULER_UNIT_DEFINES_SVH
`define PROCESS_TABLE_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pts_pkg.sv @@
// shared types and constants of the process table scheduler
package pts_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int PID_BITS_DEF  = 16;
  localparam int CHAN_BITS_DEF = 16;

  localparam int OPCODE_W  = 4;
  localparam int SLOT_W    = 6;
  localparam int CHANNEL_W = 16;
  localparam int TPID_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_PID_W = 16;

  // slot lifecycle states
  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_EMBRYO   = 3'd1;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_ZOMBIE   = 3'd5;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_MKRUN = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_SCHED = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_YIELD = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_SLEEP = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_WAKE  = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_KILL  = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_EXIT  = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_WAIT  = 4'd8;

  // result status
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SLEEP   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd3;

  // update applied to the entry read in the previous cycle
  typedef enum logic [3:0] {
    M_NONE,
    M_ALLOC,
    M_SCHED,
    M_WAKE,
    M_EXIT,
    M_REPAR,
    M_KILL,
    M_REAP,
    M_MKRUN,
    M_YIELD,
    M_SLEEP,
    M_ZOMB
  } mode_t;

  typedef struct packed {
    logic  rd_en;
    logic  clr;
    mode_t mode;
  } cmd_t;

  typedef struct packed {
    logic vld;
    logic is_unused;
    logic is_embryo;
    logic is_sleeping;
    logic is_runnable;
    logic is_running;
    logic is_zombie;
    logic pid_match;
    logic parent_match;
    logic killed;
  } flags_t;

endpackage

@@ hdl/pts_table.sv @@
// process table memory with read-modify-write update of one entry per cycle
module pts_table #(
  parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF,
  parameter int PID_BITS  = pts_pkg::PID_BITS_DEF,
  parameter int CHAN_BITS = pts_pkg::CHAN_BITS_DEF,
  localparam int SW = $clog2(NUM_SLOTS),
  localparam int PW = $clog2(NUM_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pts_pkg::cmd_t        cmd,
  input  logic [SW-1:0]        addr,
  input  logic [CHAN_BITS-1:0] key_chan,
  input  logic [PID_BITS-1:0]  key_pid,
  input  logic [PW-1:0]        key_slot,
  input  logic [PW-1:0]        new_parent,
  input  logic [PID_BITS-1:0]  new_pid,
  output pts_pkg::flags_t      flags,
  output logic [SW-1:0]        ent_addr,
  output logic [PID_BITS-1:0]  ent_pid,
  output logic [PW-1:0]        ent_parent
);

  localparam int O_PID  = 3;
  localparam int O_PAR  = O_PID + PID_BITS;
  localparam int O_CHAN = O_PAR + PW;
  localparam int O_KIL  = O_CHAN + CHAN_BITS;
  localparam int O_JW   = O_KIL + 1;
  localparam int EW     = O_JW + 1;
  localparam logic [PW-1:0] NONE_PAR = PW'(NUM_SLOTS);

  logic [EW-1:0] mem [NUM_SLOTS];
  logic [EW-1:0] rdata;
  logic [SW-1:0] raddr;
  logic          vld;

  logic [2:0]           cur_state;
  logic [PID_BITS-1:0]  cur_pid;
  logic [PW-1:0]        cur_par;
  logic [CHAN_BITS-1:0] cur_chan;
  logic                 cur_kil;
  logic                 cur_jw;

  logic [2:0]           n_state;
  logic [PID_BITS-1:0]  n_pid;
  logic [PW-1:0]        n_par;
  logic [CHAN_BITS-1:0] n_chan;
  logic                 n_kil;
  logic                 n_jw;
  logic                 we;
  logic [SW-1:0]        waddr;
  logic                 chan_hit;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[addr];
      raddr <= addr;
    end
    if (we) begin
      mem[waddr] <= {n_jw, n_kil, n_chan, n_par, n_pid, n_state};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= cmd.rd_en;
    end
  end

  assign cur_state = rdata[2:0];
  assign cur_pid   = rdata[O_PID +: PID_BITS];
  assign cur_par   = rdata[O_PAR +: PW];
  assign cur_chan  = rdata[O_CHAN +: CHAN_BITS];
  assign cur_kil   = rdata[O_KIL];
  assign cur_jw    = rdata[O_JW];
  assign chan_hit  = (cur_state == pts_pkg::ST_SLEEPING) && (cur_chan == key_chan);

  assign flags.vld          = vld;
  assign flags.is_unused    = (cur_state == pts_pkg::ST_UNUSED);
  assign flags.is_embryo    = (cur_state == pts_pkg::ST_EMBRYO);
  assign flags.is_sleeping  = (cur_state == pts_pkg::ST_SLEEPING);
  assign flags.is_runnable  = (cur_state == pts_pkg::ST_RUNNABLE);
  assign flags.is_running   = (cur_state == pts_pkg::ST_RUNNING);
  assign flags.is_zombie    = (cur_state == pts_pkg::ST_ZOMBIE);
  assign flags.pid_match    = (cur_pid == key_pid);
  assign flags.parent_match = (cur_par == key_slot);
  assign flags.killed       = cur_kil;
  assign ent_addr   = raddr;
  assign ent_pid    = cur_pid;
  assign ent_parent = cur_par;

  always_comb begin
    n_state = cur_state;
    n_pid   = cur_pid;
    n_par   = cur_par;
    n_chan  = cur_chan;
    n_kil   = cur_kil;
    n_jw    = cur_jw;
    we      = 1'b0;
    waddr   = raddr;
    if (cmd.clr) begin
      we      = 1'b1;
      waddr   = addr;
      n_state = pts_pkg::ST_UNUSED;
      n_pid   = '0;
      n_par   = NONE_PAR;
      n_chan  = '0;
      n_kil   = 1'b0;
      n_jw    = 1'b0;
    end else if (vld) begin
      case (cmd.mode)
        pts_pkg::M_ALLOC: begin
          if (flags.is_unused) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_EMBRYO;
            n_pid   = new_pid;
            n_par   = key_slot;
            n_chan  = '0;
            n_kil   = 1'b0;
            n_jw    = 1'b0;
          end
        end
        pts_pkg::M_SCHED: begin
          if (flags.is_runnable) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_RUNNING;
          end
        end
        pts_pkg::M_WAKE: begin
          if (chan_hit) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_RUNNABLE;
            n_jw    = 1'b1;
          end
        end
        pts_pkg::M_EXIT, pts_pkg::M_REPAR: begin
          if (cmd.mode == pts_pkg::M_EXIT && chan_hit) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_RUNNABLE;
            n_jw    = 1'b1;
          end
          if (flags.parent_match) begin
            we    = 1'b1;
            n_par = new_parent;
          end
        end
        pts_pkg::M_KILL: begin
          if (flags.pid_match) begin
            we    = 1'b1;
            n_kil = 1'b1;
            if (flags.is_sleeping) begin
              n_state = pts_pkg::ST_RUNNABLE;
            end
          end
        end
        pts_pkg::M_REAP: begin
          if (flags.parent_match && flags.is_zombie) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_UNUSED;
            n_pid   = '0;
            n_par   = NONE_PAR;
            n_chan  = '0;
            n_kil   = 1'b0;
            n_jw    = 1'b0;
          end
        end
        pts_pkg::M_MKRUN: begin
          if (flags.is_embryo) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_RUNNABLE;
          end
        end
        pts_pkg::M_YIELD: begin
          if (flags.is_running) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_RUNNABLE;
          end
        end
        pts_pkg::M_SLEEP: begin
          if (flags.is_running) begin
            we      = 1'b1;
            n_state = pts_pkg::ST_SLEEPING;
            n_chan  = key_chan;
          end
        end
        pts_pkg::M_ZOMB: begin
          we      = 1'b1;
          n_state = pts_pkg::ST_ZOMBIE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/process_table_scheduler_unit.sv @@
// process table scheduler top level: handshakes, sequencer and result register
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      opcode, slot, channel, target_pid
//  m_axis    out  m_axis_tvalid/tready      status, out_slot, out_pid
//  cfg       in   cfg_valid/cfg_ready       init_slot
//
// one item at a time; an item that touches one slot reads it, then updates it,
// a table scan reads the slots in turn, a wait that sleeps and an exit end by
// reading and writing their own slot, and exit with a zombie child can scan twice
// the scans are bound by the single read port of the table memory
// after reset a clearing pass writes every slot, no input taken
// the result register lets the next item enter while a result waits on m_axis
`include "process_table_scheduler_unit_defines.svh"

module process_table_scheduler_unit #(
  parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF,
  parameter int PID_BITS  = pts_pkg::PID_BITS_DEF,
  parameter int CHAN_BITS = pts_pkg::CHAN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // opcode[3:0] slot[9:4] channel[25:10] target_pid[41:26]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status[1:0] out_slot[7:2] out_pid[23:8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data        // init_slot
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int PW = $clog2(NUM_SLOTS + 1);
  localparam int CW = PW;
  localparam logic [PW-1:0] NONE_PAR = PW'(NUM_SLOTS);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDS   = 3'd2;
  localparam logic [2:0] S_CHKS  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FRD   = 3'd5;
  localparam logic [2:0] S_FWR   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  // input fields
  logic [pts_pkg::OPCODE_W-1:0]  in_opcode;
  logic [pts_pkg::SLOT_W-1:0]    in_slot;
  logic [pts_pkg::CHANNEL_W-1:0] in_channel;
  logic [pts_pkg::TPID_W-1:0]    in_tpid;
  logic [PID_BITS-1:0]           in_tpid_m;
  logic                          in_slot_ok;

  // control registers
  logic [2:0]               st;
  logic [CW-1:0]            cnt;
  logic                     pass2;
  logic                     kids;
  logic                     zflag;
  logic [PID_BITS-1:0]      next_pid;
  logic [SW-1:0]            scan_pos;
  logic [pts_pkg::SLOT_W-1:0] init_slot;

  // item registers
  logic [pts_pkg::OPCODE_W-1:0]  op_q;
  logic [pts_pkg::SLOT_W-1:0]    slot_q;
  logic [CHAN_BITS-1:0]          chan_q;
  logic [PID_BITS-1:0]           tpid_q;
  logic                          killed_q;
  logic [PW-1:0]                 parent_q;
  logic [pts_pkg::STATUS_W-1:0]  status_q;
  logic [pts_pkg::SLOT_W-1:0]    oslot_q;
  logic [pts_pkg::OUT_PID_W-1:0] opid_q;

  // table interface
  pts_pkg::cmd_t        cmd;
  pts_pkg::flags_t      flags;
  logic [SW-1:0]        tbl_addr;
  logic [CHAN_BITS-1:0] key_chan;
  logic [PW-1:0]        key_slot;
  logic [PW-1:0]        new_parent;
  logic [SW-1:0]        ent_addr;
  logic [PID_BITS-1:0]  ent_pid;
  logic [PW-1:0]        ent_parent;

  // derived
  logic [SW-1:0]   s_addr;
  logic            init_ok;
  logic [CW:0]     sched_sum;
  logic [SW-1:0]   sched_addr;
  pts_pkg::mode_t  scan_mode;
  pts_pkg::mode_t  chk_mode;
  logic            term;
  logic            hit_now;
  logic            scan_last;
  logic            kids_any;
  logic            zflag_any;

  assign in_opcode  = s_axis_tdata[3:0];
  assign in_slot    = s_axis_tdata[9:4];
  assign in_channel = s_axis_tdata[25:10];
  assign in_tpid    = s_axis_tdata[41:26];
  assign in_tpid_m  = PID_BITS'(in_tpid);
  assign in_slot_ok = (32'(in_slot) < NUM_SLOTS);

  assign s_axis_tready = (st == S_IDLE);
  assign cfg_ready     = 1'b1;

  assign s_addr     = SW'(slot_q);
  assign init_ok    = (32'(init_slot) < NUM_SLOTS);
  assign new_parent = init_ok ? PW'(init_slot) : NONE_PAR;
  assign key_slot   = PW'(slot_q);

  // round robin start point, wrapped with one compare and subtract
  assign sched_sum  = (CW + 1)'(scan_pos) + (CW + 1)'(cnt);
  assign sched_addr = (sched_sum >= (CW + 1)'(NUM_SLOTS)) ?
                      SW'(sched_sum - (CW + 1)'(NUM_SLOTS)) : SW'(sched_sum);

  // wait channel compared during scans and written on sleep
  always_comb begin
    case (op_q)
      pts_pkg::OP_EXIT: key_chan = pass2 ? CHAN_BITS'(init_slot) : CHAN_BITS'(parent_q);
      pts_pkg::OP_WAIT: key_chan = CHAN_BITS'(slot_q);
      default:          key_chan = chan_q;
    endcase
  end

  always_comb begin
    case (op_q)
      pts_pkg::OP_ALLOC: scan_mode = pts_pkg::M_ALLOC;
      pts_pkg::OP_SCHED: scan_mode = pts_pkg::M_SCHED;
      pts_pkg::OP_WAKE:  scan_mode = pts_pkg::M_WAKE;
      pts_pkg::OP_KILL:  scan_mode = pts_pkg::M_KILL;
      pts_pkg::OP_EXIT: begin
        // second pass wakes init; first pass wakes the parent unless there is none
        if (pass2) begin
          scan_mode = pts_pkg::M_WAKE;
        end else if (parent_q == NONE_PAR) begin
          scan_mode = pts_pkg::M_REPAR;
        end else begin
          scan_mode = pts_pkg::M_EXIT;
        end
      end
      pts_pkg::OP_WAIT:  scan_mode = pts_pkg::M_REAP;
      default:           scan_mode = pts_pkg::M_NONE;
    endcase
  end

  always_comb begin
    case (op_q)
      pts_pkg::OP_MKRUN: chk_mode = pts_pkg::M_MKRUN;
      pts_pkg::OP_YIELD: chk_mode = pts_pkg::M_YIELD;
      pts_pkg::OP_SLEEP: chk_mode = pts_pkg::M_SLEEP;
      default:           chk_mode = pts_pkg::M_NONE;
    endcase
  end

  // scans that stop at the first matching slot
  always_comb begin
    case (op_q)
      pts_pkg::OP_ALLOC: term = flags.is_unused;
      pts_pkg::OP_SCHED: term = flags.is_runnable;
      pts_pkg::OP_KILL:  term = flags.pid_match;
      pts_pkg::OP_WAIT:  term = flags.parent_match && flags.is_zombie;
      default:           term = 1'b0;
    endcase
  end

  assign hit_now   = (st == S_SCAN) && flags.vld && term;
  // last read was issued as cnt reached NUM_SLOTS, its data shows up now
  assign scan_last = hit_now || ((cnt == CW'(NUM_SLOTS)) && flags.vld);
  assign kids_any  = kids || (flags.vld && flags.parent_match);
  assign zflag_any = zflag || (flags.vld && flags.parent_match && flags.is_zombie);

  // table command: at most one read issued and one entry updated per cycle
  always_comb begin
    cmd.rd_en = 1'b0;
    cmd.clr   = 1'b0;
    cmd.mode  = pts_pkg::M_NONE;
    tbl_addr  = s_addr;
    case (st)
      S_CLEAR: begin
        cmd.clr  = 1'b1;
        tbl_addr = cnt[SW-1:0];
      end
      S_RDS, S_FRD: begin
        cmd.rd_en = 1'b1;
      end
      S_CHKS: begin
        cmd.mode = chk_mode;
      end
      S_SCAN: begin
        // no read past a hit, so no stale entry reaches the next state
        cmd.rd_en = (cnt < CW'(NUM_SLOTS)) && !hit_now;
        cmd.mode  = scan_mode;
        tbl_addr  = (op_q == pts_pkg::OP_SCHED) ? sched_addr : cnt[SW-1:0];
      end
      S_FWR: begin
        cmd.mode = (op_q == pts_pkg::OP_EXIT) ? pts_pkg::M_ZOMB : pts_pkg::M_SLEEP;
      end
      default: begin
      end
    endcase
  end

  pts_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .PID_BITS  (PID_BITS),
    .CHAN_BITS (CHAN_BITS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .addr       (tbl_addr),
    .key_chan   (key_chan),
    .key_pid    (tpid_q),
    .key_slot   (key_slot),
    .new_parent (new_parent),
    .new_pid    (next_pid),
    .flags      (flags),
    .ent_addr   (ent_addr),
    .ent_pid    (ent_pid),
    .ent_parent (ent_parent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_CLEAR;
      cnt           <= '0;
      pass2         <= 1'b0;
      kids          <= 1'b0;
      zflag         <= 1'b0;
      next_pid      <= PID_BITS'(1);
      scan_pos      <= '0;
      init_slot     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        init_slot <= cfg_data;
      end
      // in the finish state the result register load below takes care of it
      if (m_axis_tready && (st != S_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (st)
        S_CLEAR: begin
          if (cnt == CW'(NUM_SLOTS - 1)) begin
            cnt <= '0;
            st  <= S_IDLE;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q     <= in_opcode;
            slot_q   <= in_slot;
            chan_q   <= CHAN_BITS'(in_channel);
            tpid_q   <= in_tpid_m;
            oslot_q  <= '0;
            opid_q   <= '0;
            cnt      <= '0;
            pass2    <= 1'b0;
            kids     <= 1'b0;
            zflag    <= 1'b0;
            // pid zero never matches
            status_q <= ((in_opcode == pts_pkg::OP_KILL) && (in_tpid_m == '0)) ?
                        pts_pkg::STAT_NONE : pts_pkg::STAT_REFUSED;
            case (in_opcode)
              pts_pkg::OP_ALLOC: st <= in_slot_ok ? S_SCAN : S_FIN;
              pts_pkg::OP_MKRUN, pts_pkg::OP_YIELD, pts_pkg::OP_SLEEP,
              pts_pkg::OP_EXIT, pts_pkg::OP_WAIT: st <= in_slot_ok ? S_RDS : S_FIN;
              pts_pkg::OP_SCHED, pts_pkg::OP_WAKE: st <= S_SCAN;
              pts_pkg::OP_KILL: st <= (in_tpid_m == '0) ? S_FIN : S_SCAN;
              default: st <= S_FIN;
            endcase
          end
        end
        S_RDS: begin
          st <= S_CHKS;
        end
        S_CHKS: begin
          case (op_q)
            pts_pkg::OP_MKRUN: begin
              status_q <= flags.is_embryo ? pts_pkg::STAT_OK : pts_pkg::STAT_REFUSED;
              st       <= S_FIN;
            end
            pts_pkg::OP_YIELD: begin
              status_q <= flags.is_running ? pts_pkg::STAT_OK : pts_pkg::STAT_REFUSED;
              st       <= S_FIN;
            end
            pts_pkg::OP_SLEEP: begin
              status_q <= flags.is_running ? pts_pkg::STAT_SLEEP : pts_pkg::STAT_REFUSED;
              st       <= S_FIN;
            end
            pts_pkg::OP_EXIT: begin
              // init may not exit
              if (flags.is_running && (slot_q != init_slot)) begin
                parent_q <= ent_parent;
                st       <= S_SCAN;
              end else begin
                st <= S_FIN;
              end
            end
            pts_pkg::OP_WAIT: begin
              if (flags.is_running) begin
                killed_q <= flags.killed;
                st       <= S_SCAN;
              end else begin
                st <= S_FIN;
              end
            end
            default: begin
              st <= S_FIN;
            end
          endcase
        end
        S_SCAN: begin
          if (cmd.rd_en) begin
            cnt <= cnt + CW'(1);
          end
          if (flags.vld) begin
            kids <= kids_any;
            if (!pass2) begin
              zflag <= zflag_any;
            end
          end
          if (scan_last) begin
            case (op_q)
              pts_pkg::OP_ALLOC: begin
                st <= S_FIN;
                if (hit_now) begin
                  status_q <= pts_pkg::STAT_OK;
                  oslot_q  <= pts_pkg::SLOT_W'(ent_addr);
                  opid_q   <= pts_pkg::OUT_PID_W'(next_pid);
                  // pid wraps to one, never zero
                  next_pid <= (next_pid == '1) ? PID_BITS'(1) : next_pid + PID_BITS'(1);
                end else begin
                  status_q <= pts_pkg::STAT_NONE;
                end
              end
              pts_pkg::OP_SCHED: begin
                st <= S_FIN;
                if (hit_now) begin
                  status_q <= pts_pkg::STAT_OK;
                  oslot_q  <= pts_pkg::SLOT_W'(ent_addr);
                  scan_pos <= (ent_addr == SW'(NUM_SLOTS - 1)) ? '0 : ent_addr + SW'(1);
                end else begin
                  status_q <= pts_pkg::STAT_NONE;
                end
              end
              pts_pkg::OP_KILL: begin
                st       <= S_FIN;
                status_q <= hit_now ? pts_pkg::STAT_OK : pts_pkg::STAT_NONE;
              end
              pts_pkg::OP_WAKE: begin
                st       <= S_FIN;
                status_q <= pts_pkg::STAT_OK;
              end
              pts_pkg::OP_EXIT: begin
                // a zombie among the adopted children wakes init in a second pass
                if (!pass2 && zflag_any && init_ok) begin
                  pass2 <= 1'b1;
                  cnt   <= '0;
                  st    <= S_SCAN;
                end else begin
                  st <= S_FRD;
                end
              end
              pts_pkg::OP_WAIT: begin
                if (hit_now) begin
                  status_q <= pts_pkg::STAT_OK;
                  oslot_q  <= pts_pkg::SLOT_W'(ent_addr);
                  opid_q   <= pts_pkg::OUT_PID_W'(ent_pid);
                  st       <= S_FIN;
                end else if (!kids_any || killed_q) begin
                  status_q <= pts_pkg::STAT_NONE;
                  st       <= S_FIN;
                end else begin
                  st <= S_FRD;
                end
              end
              default: begin
                st <= S_FIN;
              end
            endcase
          end
        end
        S_FRD: begin
          st <= S_FWR;
        end
        S_FWR: begin
          status_q <= (op_q == pts_pkg::OP_EXIT) ? pts_pkg::STAT_OK : pts_pkg::STAT_SLEEP;
          st       <= S_FIN;
        end
        S_FIN: begin
          // hold until the result register is free or being emptied
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {opid_q, oslot_q, status_q};
            st            <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  `PTS_ASSERT_NXT(a_accept_leaves_idle, s_axis_tvalid && s_axis_tready, st != S_IDLE, "accepted item did not start")
  `PTS_ASSERT_IMP(a_result_from_fin, $rose(m_axis_tvalid), $past(st) == S_FIN, "result loaded outside finish")
  `PTS_ASSERT_IMP(a_read_data_expected, flags.vld, (st == S_CHKS) || (st == S_SCAN) || (st == S_FWR), "table data arrived in wrong state")
  `PTS_ASSERT_IMP(a_scan_pos_range, st != S_CLEAR, 32'(scan_pos) < NUM_SLOTS, "scan position out of range")

endmodule
